/* src/ct4_pkg.sv */
package ct4_pkg;

  localparam int SHOWN = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_MERGE,
    ST_WRITE,
    ST_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    SS_IDLE,
    SS_DIV,
    SS_SQRT,
    SS_DONE
  } calc_state_t;

  typedef struct packed {
    logic        mode;
    logic [11:0] cell_idx;
    logic [7:0]  core;
    logic [15:0] strength;
  } job_t;

endpackage

/* src/ct4_ram.sv */
module ct4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ct4_front.sv */
module ct4_front #(
  parameter int DEV_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                mode,
  input  logic [11:0]         cell_idx,
  input  logic [7:0]          core,
  input  logic [15:0]         a_in,
  input  logic [15:0]         b_in,
  output logic                q_valid,
  input  logic                q_take,
  output ct4_pkg::job_t       q_job
);
  import ct4_pkg::*;

  calc_state_t st_r, st_nxt;
  logic [16:0] den_r, den_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] op_r, op_nxt;
  logic [16:0] res_r, res_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  job_t        job_r, job_nxt;
  logic        qv_r, qv_nxt;
  job_t        qj_r, qj_nxt;

  logic [15:0] am, bm, dmask;
  logic [17:0] rsh;
  logic [33:0] trial, opw;
  logic [4:0]  pos;

  assign dmask = (DEV_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << DEV_BITS) - 32'd1);
  assign am = a_in & dmask;
  assign bm = b_in & dmask;
  assign in_full = (st_r != SS_IDLE) || qv_r;
  assign q_valid = qv_r;
  assign q_job = qj_r;

  always_comb begin
    st_nxt = st_r; den_nxt = den_r; rem_nxt = rem_r; quo_nxt = quo_r;
    op_nxt = op_r; res_nxt = res_r; cnt_nxt = cnt_r; job_nxt = job_r;
    qv_nxt = qv_r; qj_nxt = qj_r;
    rsh = {rem_r[16:0], 1'b0};
    pos = 5'd15 - cnt_r[4:0];
    trial = {15'd0, res_r, 2'b01};
    opw = {2'd0, op_r};
    if (q_take) qv_nxt = 1'b0;
    case (st_r)
      SS_IDLE: begin
        if (in_push && !in_full) begin
          job_nxt.mode = mode;
          job_nxt.cell_idx = cell_idx;
          job_nxt.core = core;
          job_nxt.strength = 16'd0;
          den_nxt = {1'b0, am} + {1'b0, bm};
          rem_nxt = {2'd0, am - bm};
          quo_nxt = '0;
          cnt_nxt = '0;
          if (mode || am <= bm) begin
            st_nxt = SS_DONE;
          end else if (bm == 16'd0) begin
            job_nxt.strength = 16'hFFFF;
            st_nxt = SS_DONE;
          end else begin
            st_nxt = SS_DIV;
          end
        end
      end
      SS_DIV: begin
        if (rsh >= {1'b0, den_r}) begin
          rem_nxt = rsh - {1'b0, den_r};
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rsh;
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          st_nxt = SS_SQRT;
          cnt_nxt = '0;
          op_nxt = quo_nxt;
          res_nxt = '0;
        end
      end
      SS_SQRT: begin
        if (opw >= (trial << {pos, 1'b0})) begin
          op_nxt = 32'(opw - (trial << {pos, 1'b0}));
          res_nxt = {res_r[15:0], 1'b1};
        end else begin
          res_nxt = {res_r[15:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd15) begin
          job_nxt.strength = res_nxt[16] ? 16'hFFFF : res_nxt[15:0];
          st_nxt = SS_DONE;
        end
      end
      SS_DONE: begin
        if (!qv_r) begin
          qv_nxt = 1'b1;
          qj_nxt = job_r;
          st_nxt = SS_IDLE;
        end
      end
      default: st_nxt = SS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SS_IDLE;
      qv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      qv_r <= qv_nxt;
    end
    den_r <= den_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt; op_r <= op_nxt;
    res_r <= res_nxt; cnt_r <= cnt_nxt; job_r <= job_nxt; qj_r <= qj_nxt;
  end

endmodule

/* src/ct4_back.sv */
module ct4_back #(
  parameter int NUM_CELLS  = 1024,
  parameter int MAX_CORES  = 32,
  parameter int LIST_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_take,
  input  ct4_pkg::job_t q_job,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [2:0]    list_count,
  output logic [5*ct4_pkg::SHOWN-1:0]  cores,
  output logic [16*ct4_pkg::SHOWN-1:0] strengths,
  output logic [15:0]   comp_strength
);
  import ct4_pkg::*;

  localparam int AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int SW = 16 * LIST_DEPTH;
  localparam int KW = 8 * LIST_DEPTH + CW;

  back_state_t st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          clr_busy_r, clr_busy_nxt;
  job_t          job_r, job_nxt;
  logic [15:0]   s_r  [LIST_DEPTH];
  logic [7:0]    c_r  [LIST_DEPTH];
  logic [CW-1:0] n_r;
  logic [15:0]   s_nxt [LIST_DEPTH];
  logic [7:0]    c_nxt [LIST_DEPTH];
  logic [CW-1:0] n_nxt;
  logic          ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [SW-1:0] swd, srd;
  logic [KW-1:0] kwd, krd;
  logic          in_rng, core_ok;

  ct4_ram #(.WIDTH(SW), .DEPTH(NUM_CELLS)) u_sram (
    .clk, .we, .waddr, .wdata(swd), .raddr, .rdata(srd));
  ct4_ram #(.WIDTH(KW), .DEPTH(NUM_CELLS)) u_kram (
    .clk, .we, .waddr, .wdata(kwd), .raddr, .rdata(krd));

  assign in_rng  = 32'(job_r.cell_idx) < NUM_CELLS;
  assign core_ok = 32'(job_r.core) < MAX_CORES;
  assign raddr   = AW'(q_job.cell_idx);
  assign out_empty = !ov_r;

  always_comb begin
    logic          found;
    logic [CW:0]   n;
    logic [15:0]   ts [LIST_DEPTH+1];
    logic [7:0]    tc [LIST_DEPTH+1];
    logic [15:0]   ks;
    logic [7:0]    kc;
    st_nxt = st_r; clr_nxt = clr_r; clr_busy_nxt = clr_busy_r; job_nxt = job_r;
    ov_nxt = ov_r; q_take = 1'b0; we = 1'b0;
    waddr = clr_r; swd = '0; kwd = '0;
    found = 1'b0; n = '0; ks = '0; kc = '0;
    for (int i = 0; i <= LIST_DEPTH; i++) begin
      ts[i] = '0; tc[i] = '0;
    end
    for (int i = 0; i < LIST_DEPTH; i++) begin
      s_nxt[i] = s_r[i]; c_nxt[i] = c_r[i];
    end
    n_nxt = n_r;
    if (out_pop && ov_r) ov_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (clr_busy_r) begin
          st_nxt = ST_CLEAR;
        end else if (q_valid && !ov_r) begin
          q_take = 1'b1;
          job_nxt = q_job;
          if (q_job.mode) begin
            clr_nxt = '0;
            st_nxt = ST_CLEAR;
          end else begin
            st_nxt = ST_READ;
          end
        end
      end
      ST_CLEAR: begin
        we = 1'b1;
        waddr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (32'(clr_r) == NUM_CELLS - 1) begin
          clr_busy_nxt = 1'b0;
          st_nxt = clr_busy_r ? ST_IDLE : ST_OUT;
          for (int i = 0; i < LIST_DEPTH; i++) begin
            s_nxt[i] = '0; c_nxt[i] = '0;
          end
          n_nxt = '0;
        end
      end
      ST_READ: begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
          s_nxt[i] = srd[16*i +: 16];
          c_nxt[i] = krd[8*i +: 8];
        end
        n_nxt = krd[KW-1 -: CW];
        st_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        n = {1'b0, n_r};
        for (int i = 0; i < LIST_DEPTH; i++) begin
          ts[i] = s_r[i]; tc[i] = c_r[i];
        end
        for (int i = 0; i < LIST_DEPTH; i++) begin
          if (!found && i < n_r && c_r[i] == job_r.core) begin
            found = 1'b1;
            ts[i] = job_r.strength;
          end
        end
        if (!found) begin
          ts[n_r] = job_r.strength;
          tc[n_r] = job_r.core;
          n = n + 1'b1;
        end
        for (int i = 1; i <= LIST_DEPTH; i++) begin
          for (int j = i; j > 0; j--) begin
            if (i < n && ts[j-1] < ts[j]) begin
              ks = ts[j]; kc = tc[j];
              ts[j] = ts[j-1]; tc[j] = tc[j-1];
              ts[j-1] = ks; tc[j-1] = kc;
            end
          end
        end
        if (in_rng && core_ok) begin
          for (int i = 0; i < LIST_DEPTH; i++) begin
            s_nxt[i] = ts[i]; c_nxt[i] = tc[i];
          end
          n_nxt = (n > LIST_DEPTH) ? CW'(LIST_DEPTH) : CW'(n);
        end
        if (!in_rng) n_nxt = '0;
        st_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        we = in_rng;
        waddr = AW'(job_r.cell_idx);
        for (int i = 0; i < LIST_DEPTH; i++) begin
          swd[16*i +: 16] = s_r[i];
          kwd[8*i +: 8] = c_r[i];
        end
        kwd[KW-1 -: CW] = n_r;
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      clr_busy_r <= clr_busy_nxt;
      clr_r <= clr_nxt;
    end
    job_r <= job_nxt;
    n_r <= n_nxt;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      s_r[i] <= s_nxt[i];
      c_r[i] <= c_nxt[i];
    end
  end

  always_comb begin
    list_count = (32'(n_r) > SHOWN) ? 3'(SHOWN) : 3'(n_r);
    for (int k = 0; k < SHOWN; k++) begin
      cores[5*k +: 5] = '0;
      strengths[16*k +: 16] = '0;
      if (k < LIST_DEPTH && k < 32'(n_r)) begin
        cores[5*k +: 5] = c_r[k % LIST_DEPTH][4:0];
        strengths[16*k +: 16] = s_r[k % LIST_DEPTH];
      end
    end
    comp_strength = job_r.mode ? 16'd0 : job_r.strength;
  end

endmodule

/* src/correlation_top4_tracker.sv */
// Flow: an update is divided, square-rooted, handed over the queue, then read,
// merged and written back; divide and root are skipped when the strength is
// zero or full scale without dividing; a clear sweeps all NUM_CELLS cells.
// The front takes a new item once it has handed the last to the back, which
// takes it only once the previous result is popped; one item per stage.
// Reset: synchronous active-low; a sweep over all NUM_CELLS addresses zeroes
// the cell memories before the back takes the first item.
module correlation_top4_tracker #(
  parameter int NUM_CELLS  = 1024,
  parameter int MAX_CORES  = 32,
  parameter int LIST_DEPTH = 4,
  parameter int DEV_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_mode,
  input  logic [9:0]  in_cell_index,
  input  logic [4:0]  in_core_id,
  input  logic [15:0] in_active_dev,
  input  logic [15:0] in_baseline_dev,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_list_count,
  output logic [4:0]  out_first_core,
  output logic [15:0] out_first_strength,
  output logic [4:0]  out_second_core,
  output logic [15:0] out_second_strength,
  output logic [4:0]  out_third_core,
  output logic [15:0] out_third_strength,
  output logic [4:0]  out_fourth_core,
  output logic [15:0] out_fourth_strength,
  output logic [15:0] out_computed_strength
);
  import ct4_pkg::*;

  logic          q_valid, q_take;
  job_t          q_job;
  logic [19:0]   cores;
  logic [63:0]   strengths;

  ct4_front #(.DEV_BITS(DEV_BITS)) u_front (
    .clk, .rst_n, .in_push, .in_full,
    .mode(in_mode), .cell_idx({2'b00, in_cell_index}), .core({3'b000, in_core_id}),
    .a_in(in_active_dev), .b_in(in_baseline_dev),
    .q_valid, .q_take, .q_job);

  ct4_back #(.NUM_CELLS(NUM_CELLS), .MAX_CORES(MAX_CORES), .LIST_DEPTH(LIST_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_job, .out_empty, .out_pop,
    .list_count(out_list_count), .cores, .strengths,
    .comp_strength(out_computed_strength));

  assign out_first_core      = cores[4:0];
  assign out_second_core     = cores[9:5];
  assign out_third_core      = cores[14:10];
  assign out_fourth_core     = cores[19:15];
  assign out_first_strength  = strengths[15:0];
  assign out_second_strength = strengths[31:16];
  assign out_third_strength  = strengths[47:32];
  assign out_fourth_strength = strengths[63:48];

endmodule

/* src/ct4_checker.sv */
module ct4_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [2:0]  out_list_count,
  input logic [15:0] out_first_strength,
  input logic [15:0] out_second_strength,
  input logic [4:0]  out_second_core
);

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_list_count <= 3'd4) else $error("count too big");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_list_count >= 3'd2) |-> out_first_strength >= out_second_strength)
    else $error("list order");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_list_count)))
    else $error("result dropped");
  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_list_count < 3'd2) |-> (out_second_core == 5'd0 &&
    out_second_strength == 16'd0)) else $error("stale slot");

endmodule

bind correlation_top4_tracker ct4_checker u_ct4_checker (
  .clk, .rst_n, .out_empty, .out_pop, .out_list_count, .out_first_strength,
  .out_second_strength, .out_second_core);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic        mode;
    logic [9:0]  cell_idx;
    logic [4:0]  core;
    logic [15:0] act;
    logic [15:0] base;
  } meas_t;

  typedef struct {
    logic [2:0]  count;
    logic [4:0]  cores [4];
    logic [15:0] strs [4];
    logic [15:0] computed;
  } list_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic        in_mode;
  logic [9:0]  in_cell_index;
  logic [4:0]  in_core_id;
  logic [15:0] in_active_dev;
  logic [15:0] in_baseline_dev;
  logic        out_empty;
  logic        out_pop;
  logic [2:0]  out_list_count;
  logic [4:0]  out_first_core, out_second_core, out_third_core, out_fourth_core;
  logic [15:0] out_first_strength, out_second_strength;
  logic [15:0] out_third_strength, out_fourth_strength;
  logic [15:0] out_computed_strength;

  correlation_top4_tracker u_dut (.*);

  meas_t       pending_items[$];
  list_t       expected_lists[$];
  logic [15:0] model_str [1024][4];
  logic [4:0]  model_core [1024][4];
  logic [2:0]  model_count [1024];
  int          errors = 0;
  int          accepted = 0;
  int          received = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          clears_sent = 0;
  bit          stim_done = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] strength_of(logic [15:0] a, logic [15:0] b);
    logic [63:0] den, rem, quo, op, res, bt;
    if (a <= b) return 16'd0;
    if (b == 0) return 16'hFFFF;
    den = a + b;
    rem = a - b;
    quo = 0;
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    op = quo;
    res = 0;
    bt = 64'd1 << 32;
    while (bt > op) bt = bt >> 2;
    while (bt != 0) begin
      if (op >= res + bt) begin
        op = op - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    if (res > 65535) res = 65535;
    return res[15:0];
  endfunction

  function automatic list_t track_item(meas_t m);
    list_t r;
    logic [15:0] s;
    logic [15:0] st [5];
    logic [4:0]  co [5];
    logic [15:0] ks;
    logic [4:0]  kc;
    int n, found, j;
    r.count = 0;
    r.computed = 0;
    for (int k = 0; k < 4; k++) begin
      r.cores[k] = 0;
      r.strs[k] = 0;
    end
    if (m.mode) begin
      for (int c = 0; c < 1024; c++) begin
        model_count[c] = 0;
        for (int k = 0; k < 4; k++) begin
          model_str[c][k] = 0;
          model_core[c][k] = 0;
        end
      end
      return r;
    end
    s = strength_of(m.act, m.base);
    n = model_count[m.cell_idx];
    found = n;
    for (int i = 0; i < n; i++) begin
      st[i] = model_str[m.cell_idx][i];
      co[i] = model_core[m.cell_idx][i];
      if (found == n && co[i] == m.core) found = i;
    end
    if (found < n) begin
      st[found] = s;
    end else begin
      st[n] = s;
      co[n] = m.core;
      n++;
    end
    for (int i = 1; i < n; i++) begin
      ks = st[i];
      kc = co[i];
      j = i;
      while (j > 0 && st[j-1] < ks) begin
        st[j] = st[j-1];
        co[j] = co[j-1];
        j--;
      end
      st[j] = ks;
      co[j] = kc;
    end
    if (n > 4) n = 4;
    for (int i = 0; i < n; i++) begin
      model_str[m.cell_idx][i] = st[i];
      model_core[m.cell_idx][i] = co[i];
      r.strs[i] = st[i];
      r.cores[i] = co[i];
    end
    model_count[m.cell_idx] = 3'(n);
    r.count = 3'(n);
    r.computed = s;
    return r;
  endfunction

  function automatic meas_t make_update(int cell_no, int core, int a, int b);
    meas_t m;
    m.mode = 1'b0;
    m.cell_idx = 10'(cell_no);
    m.core = 5'(core);
    m.act = 16'(a);
    m.base = 16'(b);
    return m;
  endfunction

  function automatic meas_t make_clear();
    meas_t m;
    m.mode = 1'b1;
    m.cell_idx = 10'($urandom);
    m.core = 5'($urandom);
    m.act = 16'($urandom);
    m.base = 16'($urandom);
    return m;
  endfunction

  task automatic queue_item(meas_t m);
    pending_items = {pending_items, m};
  endtask

  initial begin
    int hot_cells [4];
    int cl, a, b;
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    queue_item(make_update(0, 0, 0, 0));
    queue_item(make_update(0, 1, 65535, 0));
    queue_item(make_update(0, 2, 65535, 65535));
    queue_item(make_update(0, 3, 100, 200));
    queue_item(make_update(0, 4, 65535, 1));
    queue_item(make_update(0, 5, 3, 1));
    queue_item(make_update(0, 3, 50000, 10000));
    queue_item(make_update(0, 31, 1, 0));
    queue_item(make_update(1023, 31, 40000, 20000));
    queue_item(make_update(1023, 7, 40000, 20000));
    queue_item(make_update(1023, 9, 40000, 20000));
    queue_item(make_update(1023, 7, 65535, 32768));
    queue_item(make_update(1023, 0, 1, 1));
    queue_item(make_update(1023, 12, 2, 1));
    queue_item(make_update(512, 21, 43690, 21845));
    queue_item(make_clear());
    queue_item(make_update(0, 1, 1, 0));
    queue_item(make_update(1023, 10, 21845, 43690));
    for (int i = 0; i < 4; i++) hot_cells[i] = $urandom_range(0, 1023);
    for (int i = 0; i < 1100; i++) begin
      if ($urandom_range(0, 99) == 0) begin
        queue_item(make_clear());
        continue;
      end
      if ($urandom_range(0, 9) < 7) cl = hot_cells[$urandom_range(0, 3)];
      else cl = $urandom_range(0, 1023);
      case ($urandom_range(0, 4))
        0: begin
          a = $urandom_range(0, 65535);
          b = $urandom_range(0, 65535);
        end
        1: begin
          a = $urandom_range(0, 255);
          b = $urandom_range(0, 255);
        end
        2: begin
          a = $urandom_range(0, 65535);
          b = 0;
        end
        3: begin
          a = $urandom_range(0, 65535);
          b = a;
        end
        default: begin
          b = $urandom_range(0, 60000);
          a = b + $urandom_range(0, 65535 - b);
        end
      endcase
      queue_item(make_update(cl, $urandom_range(0, 31), a, b));
    end
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 0;
      in_mode <= 0;
      in_cell_index <= 0;
      in_core_id <= 0;
      in_active_dev <= 0;
      in_baseline_dev <= 0;
    end else begin
      if (in_push && !in_full) begin
        expected_lists = {expected_lists, track_item(pending_items.pop_front())};
        if (in_mode) clears_sent++;
        accepted++;
      end
      if (!(in_push && in_full)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_push <= 0;
        end else if (pending_items.size() > 0) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
          end
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
          in_push <= 1;
          in_mode <= pending_items[0].mode;
          in_cell_index <= pending_items[0].cell_idx;
          in_core_id <= pending_items[0].core;
          in_active_dev <= pending_items[0].act;
          in_baseline_dev <= pending_items[0].base;
        end else begin
          in_push <= 0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    list_t e;
    int ph;
    if (!rst_n) begin
      out_pop <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        received++;
        if (expected_lists.size() == 0) begin
          $display("%0t unexpected result: expected none actual count %0d",
                   $time, out_list_count);
          errors++;
        end else begin
          e = expected_lists.pop_front();
          check_field("list_count", 16'(e.count), 16'(out_list_count));
          check_field("first_core", 16'(e.cores[0]), 16'(out_first_core));
          check_field("first_strength", e.strs[0], out_first_strength);
          check_field("second_core", 16'(e.cores[1]), 16'(out_second_core));
          check_field("second_strength", e.strs[1], out_second_strength);
          check_field("third_core", 16'(e.cores[2]), 16'(out_third_core));
          check_field("third_strength", e.strs[2], out_third_strength);
          check_field("fourth_core", 16'(e.cores[3]), 16'(out_fourth_core));
          check_field("fourth_strength", e.strs[3], out_fourth_strength);
          check_field("computed_strength", e.computed, out_computed_strength);
        end
      end
      ph = int'(($time / 10) % 600);
      if (ph < 150) out_pop <= 1;
      else if (ph < 300) out_pop <= ($urandom_range(0, 3) != 0);
      else out_pop <= ($urandom_range(0, 9) < 3);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("timeout with %0d results outstanding", expected_lists.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (rst_n && pending_items.size() == 0 && !in_push);
    wait (expected_lists.size() == 0);
    repeat (200) @(posedge clk);
    $display("ran %0d items (%0d clears), checked %0d results, %0d errors",
             accepted, clears_sent, received, errors);
    if (errors == 0 && expected_lists.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
